// File: src/kot_pkg.sv
// Shared types and constants of the key/owner table.
`default_nettype none

package kot_pkg;

    localparam int KEY_W               = 64;
    localparam int OWNER_W             = 16;
    localparam int DEFAULT_TABLE_DEPTH = 32;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_LIST   = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [OWNER_W-1:0] owner;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [KEY_W-1:0]   key_out;
        logic [OWNER_W-1:0] owner_out;
        logic               last;
    } t_rsp;

endpackage

`default_nettype wire

// File: src/kot_req_if.sv
// Request channel of the key/owner table.
`default_nettype none

interface kot_req_if import kot_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         cmd;
    logic [KEY_W-1:0]   key;
    logic [OWNER_W-1:0] owner;

    modport source (output valid, output cmd, output key, output owner, input ready);
    modport sink   (input valid, input cmd, input key, input owner, output ready);
endinterface

`default_nettype wire

// File: src/kot_rsp_if.sv
// Response channel of the key/owner table.
`default_nettype none

interface kot_rsp_if import kot_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic               found;
    logic [KEY_W-1:0]   key_out;
    logic [OWNER_W-1:0] owner_out;
    logic               last;

    modport source (output valid, output status, output found, output key_out,
                    output owner_out, output last, input ready);
    modport sink   (input valid, input status, input found, input key_out,
                    input owner_out, input last, output ready);
endinterface

`default_nettype wire

// File: src/key_owner_table.sv
// Key/owner table: a bounded list of key/owner pairs with insert, lookup, remove,
// list by owner and clear.
//
// Requests arrive on i_req (cmd, key, owner) and results leave on o_rsp; each side
// moves one transaction when valid and ready are both high. Every request gives at
// least one result, and the final result of a request carries last.
// One request is worked on at a time; i_req.ready is high whenever the block is idle,
// also while the previous result still waits in the output register.
// Insert, clear and unused codes: the result is registered from the execute state.
// Lookup and remove scan the stored entries newest first, list scans oldest first,
// one entry per cycle unless a result waits, through the single read port of the entry
// memory. A remove then moves the entries above the hit down by one, one per cycle.
// List holds each match back until the next match or the end of the scan, so that
// the final one can carry last.
// A stalled receiver holds the output register, and the scan waits whenever it has a
// result to hand over. Reset empties the table at once; no clearing pass is needed.
`default_nettype none

module key_owner_table import kot_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kot_req_if.sink    i_req,
    kot_rsp_if.source  o_rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state             r_state,      n_state;
    logic [2:0]         r_cmd,        n_cmd;
    logic [KEY_W-1:0]   r_key,        n_key;
    logic [OWNER_W-1:0] r_owner,      n_owner;
    logic [CNT_W-1:0]   r_count,      n_count;
    logic [IDX_W-1:0]   r_issue_idx,  n_issue_idx;
    logic [CNT_W-1:0]   r_left,       n_left;
    logic               r_data_valid, n_data_valid;
    logic [IDX_W-1:0]   r_data_idx,   n_data_idx;
    logic               r_pend_valid, n_pend_valid;
    t_entry             r_pend,       n_pend;
    logic               r_out_valid,  n_out_valid;
    t_rsp               r_out,        n_out;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    t_entry           rd_data;

    logic out_free;
    logic scan_hit;
    logic scan_end;
    logic dir_up;
    logic advance;
    logic emit;
    t_rsp emit_rsp;
    t_rsp rsp_plain;

    kot_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign scan_hit  = r_data_valid && ((r_cmd == CMD_LIST) ? (rd_data.owner == r_owner)
                                                            : (rd_data.key == r_key));
    assign scan_end  = !r_data_valid && (r_left == '0);
    assign dir_up    = (r_state == S_SHIFT) || (r_cmd == CMD_LIST);
    assign rsp_plain = '{status: ST_OK, found: 1'b0, key_out: '0, owner_out: '0, last: 1'b1};

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_owner      = r_owner;
        n_count      = r_count;
        n_issue_idx  = r_issue_idx;
        n_left       = r_left;
        n_data_valid = r_data_valid;
        n_data_idx   = r_data_idx;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        rd_en        = 1'b0;
        rd_addr      = r_issue_idx;
        wr_en        = 1'b0;
        wr_addr      = r_count[IDX_W-1:0];
        wr_data      = '{key: r_key, owner: r_owner};
        advance      = 1'b0;
        emit         = 1'b0;
        emit_rsp     = rsp_plain;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cmd   = i_req.cmd;
                    n_key   = i_req.key;
                    n_owner = i_req.owner;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                emit_rsp.status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_LOOKUP, CMD_REMOVE: begin
                        n_left       = r_count;
                        n_issue_idx  = IDX_W'(r_count - CNT_W'(1));
                        n_data_valid = 1'b0;
                        n_state      = S_SCAN;
                    end
                    CMD_LIST: begin
                        n_left       = r_count;
                        n_issue_idx  = '0;
                        n_data_valid = 1'b0;
                        n_pend_valid = 1'b0;
                        n_state      = S_SCAN;
                    end
                    CMD_CLEAR: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_count = '0;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (r_cmd == CMD_LIST) begin
                    priority if (scan_end) begin
                        if (out_free) begin
                            emit = 1'b1;
                            if (r_pend_valid) begin
                                emit_rsp.found     = 1'b1;
                                emit_rsp.key_out   = r_pend.key;
                                emit_rsp.owner_out = r_pend.owner;
                            end else begin
                                emit_rsp.status = ST_NOT_FOUND;
                            end
                            n_state = S_IDLE;
                        end
                    end else if (scan_hit && r_pend_valid) begin
                        if (out_free) begin
                            emit               = 1'b1;
                            emit_rsp.found     = 1'b1;
                            emit_rsp.key_out   = r_pend.key;
                            emit_rsp.owner_out = r_pend.owner;
                            emit_rsp.last      = 1'b0;
                            n_pend             = rd_data;
                            advance            = 1'b1;
                        end
                    end else if (scan_hit) begin
                        n_pend_valid = 1'b1;
                        n_pend       = rd_data;
                        advance      = 1'b1;
                    end else begin
                        advance = 1'b1;
                    end
                end else begin
                    priority if (scan_end) begin
                        if (out_free) begin
                            emit            = 1'b1;
                            emit_rsp.status = ST_NOT_FOUND;
                            n_state         = S_IDLE;
                        end
                    end else if (scan_hit) begin
                        if (out_free) begin
                            emit               = 1'b1;
                            emit_rsp.found     = 1'b1;
                            emit_rsp.key_out   = rd_data.key;
                            emit_rsp.owner_out = rd_data.owner;
                            if (r_cmd == CMD_REMOVE) begin
                                n_issue_idx  = r_data_idx + IDX_W'(1);
                                n_left       = r_count - CNT_W'(r_data_idx) - CNT_W'(1);
                                n_data_valid = 1'b0;
                                n_state      = S_SHIFT;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                    end else begin
                        advance = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                wr_en   = r_data_valid;
                wr_addr = r_data_idx - IDX_W'(1);
                wr_data = rd_data;
                advance = 1'b1;
                if (scan_end) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (advance) begin
            rd_en        = (r_left != '0);
            n_data_valid = (r_left != '0);
            n_data_idx   = r_issue_idx;
            n_issue_idx  = dir_up ? (r_issue_idx + IDX_W'(1)) : (r_issue_idx - IDX_W'(1));
            if (r_left != '0) begin
                n_left = r_left - CNT_W'(1);
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = emit_rsp;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_left       <= '0;
            r_data_valid <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_left       <= n_left;
            r_data_valid <= n_data_valid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_key       <= n_key;
        r_owner     <= n_owner;
        r_issue_idx <= n_issue_idx;
        r_data_idx  <= n_data_idx;
        r_pend      <= n_pend;
        r_out       <= n_out;
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out.status;
    assign o_rsp.found     = r_out.found;
    assign o_rsp.key_out   = r_out.key_out;
    assign o_rsp.owner_out = r_out.owner_out;
    assign o_rsp.last      = r_out.last;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !wr_en)
        else $error("Entry memory written during a scan.");

    a_shift_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && n_state == S_IDLE) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("Removal did not shrink the table by one entry.");

endmodule

`default_nettype wire

// File: src/kot_store.sv
// Entry memory of the key/owner table: one write port, one registered read port.
`default_nettype none

module kot_store import kot_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rd_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    input  wire logic                           i_wr_en,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0] i_wr_addr,
    input  wire t_entry                         i_wr_data,
    output t_entry                              o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
